[design/assert_macros.svh]
// Assertion helpers, included by the skinning core top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent implication check, disabled while reset is high
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication check, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/svt_pkg.sv]
// -----------------------------------------------------------------------------
// svt_pkg
// Shared types and constants of the skinned vertex transform core.
// -----------------------------------------------------------------------------
package svt_pkg;

   localparam int NUM_BONES  = 64;
   localparam int FRAC_BITS  = 16;
   localparam int BONE_W     = 6;
   localparam int PAL_AW     = $clog2(NUM_BONES) + 2;  // row address, 4 words a row
   localparam int PROD_W     = 49;                     // 16u x 32s product
   localparam int BLEND_W    = 51;                     // sum of four products
   localparam int TERM_W     = 84;                     // blend x 32s vector
   localparam int ACC_W      = 87;                     // sum of four terms
   localparam int SHIFT      = FRAC_BITS + 15;
   localparam int QDEPTH     = 2;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_POINT = 2'd1;
   localparam logic [1:0] CMD_DIR   = 2'd2;

   typedef struct packed {
      logic [3:0][BONE_W-1:0]   bone;
      logic [3:0]               bone_ok;
      logic [3:0][15:0]         weight;
      logic signed [31:0]       vec_x;
      logic signed [31:0]       vec_y;
      logic signed [31:0]       vec_z;
      logic                     is_point;
   } job_type;

   typedef struct packed {
      logic        wr_en;
      logic [PAL_AW-1:0] wr_row;
      logic [1:0]  wr_col;
      logic [31:0] wr_data;
   } pal_wr_type;

endpackage

[design/skinned_vertex_transform_core.sv]
// -----------------------------------------------------------------------------
// skinned_vertex_transform_core
// Four-bone linear blend skinning of points and directions, Q16.16.
// -----------------------------------------------------------------------------
// Vertices: one at a time in the back end, which takes a queued job after the result
//    beat has gone; the front queues up to two more. A job runs through a take, palette
//    reads (16 four-word rows plus one), multiply steps (12 products in two halves), a
//    sum, rounding of x, y and z and the output beat. Loads: one a cycle, no result beat;
//    held while a job is queued or reading the palette, or while the job queue is full.
// Reset: synchronous, clears control; palette is undefined until written.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module skinned_vertex_transform_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [5:0]         req_bone_a,
   input  logic [5:0]         req_bone_b,
   input  logic [5:0]         req_bone_c,
   input  logic [5:0]         req_bone_d,
   input  logic [15:0]        req_weight_a,
   input  logic [15:0]        req_weight_b,
   input  logic [15:0]        req_weight_c,
   input  logic [15:0]        req_weight_d,
   input  logic signed [31:0] req_vec_x,
   input  logic signed [31:0] req_vec_y,
   input  logic signed [31:0] req_vec_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic               rsp_saturated
);
   import svt_pkg::*;

   pal_wr_type pal_wr;
   job_type    job;
   logic       job_valid, job_take;
   logic       pal_busy;

   // Front: accept beats, write loads straight into the palette, queue jobs
   svt_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_cmd,
      .req_bone_a, .req_bone_b, .req_bone_c, .req_bone_d,
      .req_weight_a, .req_weight_b, .req_weight_c, .req_weight_d,
      .req_vec_x, .req_vec_y, .req_vec_z,
      .pal_busy, .pal_wr, .job_valid, .job, .job_take
   );

   // Back: blend the four bone matrices and transform the vector
   svt_back u_back (
      .clock, .reset, .pal_wr, .job_valid, .job, .job_take, .pal_busy,
      .rsp_valid, .rsp_stall, .rsp_out_x, .rsp_out_y, .rsp_out_z, .rsp_saturated
   );

   // A job is taken only when one is queued
   `ASSERT_IMPL(a_take_has_job, clock, reset, job_take, job_valid, "job taken from empty queue")
   // Never take a new job while a result beat waits
   `ASSERT_IMPL(a_no_take_on_rsp, clock, reset, rsp_valid, !job_take, "job taken during result")
   // A stalled result beat holds its x component and saturation flag
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                rsp_valid && $stable(rsp_out_x) && $stable(rsp_saturated), "result changed")

endmodule

[design/svt_front.sv]
// -----------------------------------------------------------------------------
// svt_front
// Accepts request beats, writes palette loads, queues transform jobs.
// -----------------------------------------------------------------------------
module svt_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_cmd,
   input  logic [5:0]           req_bone_a,
   input  logic [5:0]           req_bone_b,
   input  logic [5:0]           req_bone_c,
   input  logic [5:0]           req_bone_d,
   input  logic [15:0]          req_weight_a,
   input  logic [15:0]          req_weight_b,
   input  logic [15:0]          req_weight_c,
   input  logic [15:0]          req_weight_d,
   input  logic signed [31:0]   req_vec_x,
   input  logic signed [31:0]   req_vec_y,
   input  logic signed [31:0]   req_vec_z,
   input  logic                 pal_busy,
   output svt_pkg::pal_wr_type  pal_wr,
   output logic                 job_valid,
   output svt_pkg::job_type     job,
   input  logic                 job_take
);
   import svt_pkg::*;

   job_type           q_ff [QDEPTH];
   logic              wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              acc, is_xf, push;
   job_type           nj;

   // Stall while the queue is full; hold a load until every earlier job has
   // finished reading the palette
   assign req_stall = (cnt_ff == 2'(QDEPTH)) ||
                      ((req_cmd == CMD_LOAD) && ((cnt_ff != 2'd0) || pal_busy));
   assign acc       = req_valid && !req_stall;
   assign is_xf     = (req_cmd == CMD_POINT) || (req_cmd == CMD_DIR);
   assign push      = acc && is_xf;

   always_comb begin
      nj.bone     = {req_bone_d, req_bone_c, req_bone_b, req_bone_a};
      nj.bone_ok  = {({2'b0, req_bone_d} < 8'(NUM_BONES)), ({2'b0, req_bone_c} < 8'(NUM_BONES)),
                     ({2'b0, req_bone_b} < 8'(NUM_BONES)), ({2'b0, req_bone_a} < 8'(NUM_BONES))};
      nj.weight   = {req_weight_d, req_weight_c, req_weight_b, req_weight_a};
      nj.vec_x    = req_vec_x;
      nj.vec_y    = req_vec_y;
      nj.vec_z    = req_vec_z;
      nj.is_point = (req_cmd == CMD_POINT);
   end

   always_comb begin
      pal_wr.wr_en   = acc && (req_cmd == CMD_LOAD) &&
                       ({2'b0, req_bone_a} < 8'(NUM_BONES)) && (req_bone_b < 6'd16);
      pal_wr.wr_row  = PAL_AW'({req_bone_a, req_bone_b[3:2]});
      pal_wr.wr_col  = req_bone_b[1:0];
      pal_wr.wr_data = req_vec_x;
   end

   always_comb begin
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ job_take;
      cnt_in  = cnt_ff + 2'(push) - 2'(job_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
      if (push) q_ff[wptr_ff] <= nj;
   end

   assign job_valid = (cnt_ff != 2'd0);
   assign job       = q_ff[rptr_ff];
endmodule

[design/svt_back.sv]
// -----------------------------------------------------------------------------
// svt_back
// Reads the palette four words a cycle, blends, transforms, rounds, saturates.
// -----------------------------------------------------------------------------
module svt_back (
   input  logic                 clock,
   input  logic                 reset,
   input  svt_pkg::pal_wr_type  pal_wr,
   input  logic                 job_valid,
   input  svt_pkg::job_type     job,
   output logic                 job_take,
   output logic                 pal_busy,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [31:0]   rsp_out_x,
   output logic signed [31:0]   rsp_out_y,
   output logic signed [31:0]   rsp_out_z,
   output logic                 rsp_saturated
);
   import svt_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_BLEND = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_SUM   = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   localparam int LO_W = 26;               // low part of a blended entry

   // Palette: one row of four 32-bit words per address
   logic [3:0][31:0]  pal_mem [NUM_BONES*4];

   logic [2:0]        st_ff, st_in;
   job_type           j_ff;
   logic [3:0]        step_ff, step_in;    // bone in [3:2], row in [1:0]
   logic [1:0]        rd_bone, rd_row;
   logic              rd_vld_ff;
   logic [1:0]        rdb_ff, rdr_ff;
   logic              rd_last_ff;
   logic [3:0][31:0]  rd_data_ff;
   logic [3:0][PROD_W-1:0]  prod;
   logic signed [BLEND_W-1:0] blend_ff [16];
   logic [1:0]        mr_ff;               // output row in multiply
   logic [1:0]        mc_ff;               // column in multiply
   logic              half_ff;             // 0 low part, 1 high part
   logic signed [TERM_W-1:0]  term_ff;
   logic signed [ACC_W-1:0]   acc_ff [3];
   logic              term_vld_ff;
   logic [1:0]        term_row_ff;
   logic              mul_done_ff;
   logic [1:0]        fin_ff;
   logic signed [31:0] o_ff [3];
   logic              sat_ff;
   logic signed [31:0] vsel;
   logic signed [BLEND_W-1:0] bsel;
   logic signed [LO_W:0]      mhalf;
   logic signed [TERM_W-1:0]  mprod;
   logic signed [ACC_W-1:0]   rnd;
   logic signed [ACC_W-SHIFT-1:0] shv;
   logic              hi_ok, lo_ok;
   logic signed [31:0] fin_val;

   assign rd_bone  = step_ff[3:2];
   assign rd_row   = step_ff[1:0];
   assign job_take = (st_ff == ST_IDLE) && job_valid;
   assign pal_busy = (st_ff == ST_BLEND);

   always_ff @(posedge clock) begin
      if (pal_wr.wr_en) pal_mem[pal_wr.wr_row][pal_wr.wr_col] <= pal_wr.wr_data;
      rd_data_ff <= pal_mem[PAL_AW'({j_ff.bone[rd_bone], rd_row})];
   end

   // Four products of one weight with a row of four words
   always_comb begin
      for (int k = 0; k < 4; k++)
         prod[k] = PROD_W'($signed({1'b0, j_ff.weight[rdb_ff]}) * $signed(rd_data_ff[k]));
   end

   always_comb begin
      unique case (mc_ff)
         2'd0:    vsel = j_ff.vec_x;
         2'd1:    vsel = j_ff.vec_y;
         2'd2:    vsel = j_ff.vec_z;
         default: vsel = j_ff.is_point ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
      endcase
      bsel  = blend_ff[{mr_ff, mc_ff}];
      mhalf = half_ff ? {{(2*LO_W+1-BLEND_W){bsel[BLEND_W-1]}}, bsel[BLEND_W-1:LO_W]}
                      : {1'b0, bsel[LO_W-1:0]};
      mprod = TERM_W'(mhalf * vsel);
   end

   always_comb begin
      rnd     = acc_ff[fin_ff] + (ACC_W'(1) <<< (SHIFT - 1));
      shv     = rnd[ACC_W-1:SHIFT];
      hi_ok   = (shv[ACC_W-SHIFT-1:31] == '0);
      lo_ok   = (shv[ACC_W-SHIFT-1:31] == '1);
      fin_val = (hi_ok || lo_ok) ? shv[31:0]
              : (shv[ACC_W-SHIFT-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
   end

   always_comb begin
      st_in   = st_ff;
      step_in = step_ff;
      unique case (st_ff)
         ST_IDLE:  if (job_valid) begin
            st_in   = ST_BLEND;
            step_in = 4'd0;
         end
         ST_BLEND: begin
            step_in = step_ff + 4'd1;
            if (rd_last_ff) st_in = ST_MUL;
         end
         ST_MUL:   if (mul_done_ff) st_in = ST_SUM;
         ST_SUM:   if (!term_vld_ff) st_in = ST_FIN;
         ST_FIN:   if (fin_ff == 2'd2) st_in = ST_OUT;
         ST_OUT:   if (!rsp_stall) st_in = ST_IDLE;
         default:  st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= ST_IDLE;
         rd_vld_ff   <= 1'b0;
         rd_last_ff  <= 1'b0;
         term_vld_ff <= 1'b0;
         mul_done_ff <= 1'b0;
      end else begin
         st_ff       <= st_in;
         // Issue one row read a cycle through all 16 steps
         rd_vld_ff   <= (st_ff == ST_BLEND) && !rd_last_ff && (step_ff != 4'd0 || !rd_vld_ff);
         rd_last_ff  <= (st_ff == ST_BLEND) && (step_ff == 4'd15) && !rd_last_ff;
         term_vld_ff <= (st_ff == ST_MUL) && !mul_done_ff;
         mul_done_ff <= (st_ff == ST_MUL) && (mr_ff == 2'd2) && (mc_ff == 2'd3) && half_ff;
      end
      step_ff <= step_in;
      rdb_ff  <= rd_bone;
      rdr_ff  <= rd_row;
      if (job_take) j_ff <= job;
      if (st_ff == ST_IDLE) begin
         for (int k = 0; k < 16; k++) blend_ff[k] <= '0;
         mr_ff <= 2'd0;
         mc_ff <= 2'd0;
         half_ff <= 1'b0;
         fin_ff <= 2'd0;
         sat_ff <= 1'b0;
         for (int r = 0; r < 3; r++) acc_ff[r] <= '0;
      end
      // Accumulate one weighted row of the blended matrix
      if (rd_vld_ff && j_ff.bone_ok[rdb_ff]) begin
         for (int k = 0; k < 4; k++)
            blend_ff[{rdr_ff, 2'(k)}] <= blend_ff[{rdr_ff, 2'(k)}] +
               BLEND_W'($signed(prod[k]));
      end
      // Half a blend x vector product a cycle, low part then high part,
      // registered, then added
      if (st_ff == ST_MUL && !mul_done_ff) begin
         term_ff     <= half_ff ? (mprod <<< LO_W) : mprod;
         term_row_ff <= mr_ff;
         half_ff     <= !half_ff;
         if (half_ff) {mr_ff, mc_ff} <= {mr_ff, mc_ff} + 4'd1;
      end
      if (term_vld_ff)
         acc_ff[term_row_ff] <= acc_ff[term_row_ff] + ACC_W'(term_ff);
      if (st_ff == ST_FIN) begin
         o_ff[fin_ff] <= fin_val;
         if (!(hi_ok || lo_ok)) sat_ff <= 1'b1;
         fin_ff <= fin_ff + 2'd1;
      end
   end

   assign rsp_valid     = (st_ff == ST_OUT);
   assign rsp_out_x     = o_ff[0];
   assign rsp_out_y     = o_ff[1];
   assign rsp_out_z     = o_ff[2];
   assign rsp_saturated = sat_ff;
endmodule

[tb/skinned_vertex_transform_checker.sv]
// -----------------------------------------------------------------------------
// skinned_vertex_transform_checker
// Watches both channels of the skinning core, keeps a shadow bone palette,
// predicts each transform beat and compares result beats in order.
// -----------------------------------------------------------------------------
`timescale 1ns / 100ps

module skinned_vertex_transform_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic [5:0]         req_bone_a,
   input  logic [5:0]         req_bone_b,
   input  logic [5:0]         req_bone_c,
   input  logic [5:0]         req_bone_d,
   input  logic [15:0]        req_weight_a,
   input  logic [15:0]        req_weight_b,
   input  logic [15:0]        req_weight_c,
   input  logic [15:0]        req_weight_d,
   input  logic signed [31:0] req_vec_x,
   input  logic signed [31:0] req_vec_y,
   input  logic signed [31:0] req_vec_z,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_out_x,
   input  logic signed [31:0] rsp_out_y,
   input  logic signed [31:0] rsp_out_z,
   input  logic               rsp_saturated,
   output int                 mismatches,
   output int                 pending
);
   import svt_pkg::*;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               sat;
   } vertex_out_type;

   logic signed [31:0] shadow_palette [NUM_BONES*16];
   vertex_out_type     vertex_queue[$];

   function automatic vertex_out_type skin_vertex(
      input logic [1:0] cmd, input logic [3:0][5:0] bones,
      input logic [3:0][15:0] weights,
      input logic signed [31:0] vx, input logic signed [31:0] vy,
      input logic signed [31:0] vz);
      longint             blend [16];
      logic signed [127:0] vec [4];
      logic signed [127:0] acc, b128;
      logic signed [31:0]  comp [3];
      vertex_out_type      res;
      res.sat = 1'b0;
      for (int k = 0; k < 16; k++) blend[k] = 0;
      for (int i = 0; i < 4; i++) begin
         if (bones[i] < NUM_BONES) begin
            for (int k = 0; k < 16; k++)
               blend[k] += longint'(weights[i]) * longint'(shadow_palette[bones[i]*16 + k]);
         end
      end
      vec[0] = vx;
      vec[1] = vy;
      vec[2] = vz;
      vec[3] = (cmd == CMD_POINT) ? 128'sd1 <<< FRAC_BITS : 128'sd0;
      for (int r = 0; r < 3; r++) begin
         acc = 0;
         for (int c = 0; c < 4; c++) begin
            b128 = blend[r*4 + c];
            acc += b128 * vec[c];
         end
         // round half up, then drop the weight and fraction bits
         acc = (acc + (128'sd1 <<< (SHIFT - 1))) >>> SHIFT;
         if (acc > 128'sh7FFF_FFFF) begin
            comp[r] = 32'sh7FFF_FFFF;
            res.sat = 1'b1;
         end else if (acc < -128'sh8000_0000) begin
            comp[r] = 32'sh8000_0000;
            res.sat = 1'b1;
         end else begin
            comp[r] = acc[31:0];
         end
      end
      res.x = comp[0];
      res.y = comp[1];
      res.z = comp[2];
      return res;
   endfunction

   assign pending = vertex_queue.size();

   always @(posedge clock) begin
      vertex_out_type want;
      if (reset) begin
         mismatches <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (req_cmd == CMD_LOAD) begin
               if (req_bone_a < NUM_BONES && req_bone_b < 16)
                  shadow_palette[req_bone_a*16 + req_bone_b] = req_vec_x;
            end else if (req_cmd == CMD_POINT || req_cmd == CMD_DIR) begin
               vertex_queue.push_back(skin_vertex(req_cmd,
                  {req_bone_d, req_bone_c, req_bone_b, req_bone_a},
                  {req_weight_d, req_weight_c, req_weight_b, req_weight_a},
                  req_vec_x, req_vec_y, req_vec_z));
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (vertex_queue.size() == 0) begin
               if (mismatches < 10)
                  $display("result beat with nothing expected: x=%0d y=%0d z=%0d sat=%0b",
                           rsp_out_x, rsp_out_y, rsp_out_z, rsp_saturated);
               mismatches <= mismatches + 1;
            end else begin
               want = vertex_queue.pop_front();
               if (want.x !== rsp_out_x || want.y !== rsp_out_y ||
                   want.z !== rsp_out_z || want.sat !== rsp_saturated) begin
                  if (mismatches < 10)
                     $display({"mismatch: exp x=%0d y=%0d z=%0d sat=%0b",
                               " got x=%0d y=%0d z=%0d sat=%0b"},
                              want.x, want.y, want.z, want.sat,
                              rsp_out_x, rsp_out_y, rsp_out_z, rsp_saturated);
                  mismatches <= mismatches + 1;
               end
            end
         end
      end
   end

endmodule

[tb/tb.sv]
// -----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the skinning core: fills the palette, runs directed
// corner beats, then a long random mix of loads, transforms and spare beats with
// idling on both sides, one long result hold-off and one drain pause.
// -----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import svt_pkg::*;

   localparam int RANDOM_BEATS = 370;
   localparam int IDLE_LIMIT   = 3000;
   localparam int LONG_HOLD    = 400;
   localparam logic [1:0] CMD_SPARE = 2'd3;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_cmd = CMD_LOAD;
   logic [5:0]         req_bone_a = '0, req_bone_b = '0, req_bone_c = '0, req_bone_d = '0;
   logic [15:0]        req_weight_a = '0, req_weight_b = '0;
   logic [15:0]        req_weight_c = '0, req_weight_d = '0;
   logic signed [31:0] req_vec_x = '0, req_vec_y = '0, req_vec_z = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic               rsp_saturated;
   int                 mismatches, pending;

   // tail of the run: no idling on either side
   bit quiet_tail = 0;
   bit hold_now   = 0;

   skinned_vertex_transform_core u_top (.*);

   skinned_vertex_transform_checker u_checker (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Drive one beat and hold it until the core takes it.
   task automatic send_beat(input logic [1:0] cmd, input logic [3:0][5:0] bones,
                            input logic [3:0][15:0] weights,
                            input logic [31:0] vx, input logic [31:0] vy,
                            input logic [31:0] vz);
      int gap;
      gap = (!quiet_tail && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_bone_a   <= bones[0];
      req_bone_b   <= bones[1];
      req_bone_c   <= bones[2];
      req_bone_d   <= bones[3];
      req_weight_a <= weights[0];
      req_weight_b <= weights[1];
      req_weight_c <= weights[2];
      req_weight_d <= weights[3];
      req_vec_x    <= vx;
      req_vec_y    <= vy;
      req_vec_z    <= vz;
      do @(posedge clock); while (req_stall);
   endtask

   // Palette entries: mostly modest Q16.16 values, some full range and extremes.
   function automatic logic [31:0] pick_entry();
      case ($urandom_range(0, 9))
         0:       return $urandom();
         1:       return 32'h8000_0000;
         2:       return 32'h7FFF_FFFF;
         default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      endcase
   endfunction

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 7))
         0:       return $urandom();
         1:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         default: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      endcase
   endfunction

   task automatic send_random_vertex();
      logic [3:0][5:0]  bones;
      logic [3:0][15:0] weights;
      int               left;
      for (int i = 0; i < 4; i++) bones[i] = 6'($urandom_range(0, 63));
      case ($urandom_range(0, 3))
         0: for (int i = 0; i < 4; i++) weights[i] = 16'($urandom());
         1: weights = {16'd0, 16'd0, 16'd0, 16'd32768};
         default: begin
            // weights that sum to one, as a rig would give
            left = 32768;
            for (int i = 0; i < 3; i++) begin
               weights[i] = 16'($urandom_range(0, left));
               left -= weights[i];
            end
            weights[3] = 16'(left);
         end
      endcase
      send_beat($urandom_range(0, 1) ? CMD_POINT : CMD_DIR, bones, weights,
                pick_coord(), pick_coord(), pick_coord());
   endtask

   // Result side: random stall bursts, one long hold, none in the tail.
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (hold_now) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            hold_now = 0;
            rsp_stall <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            n = $urandom_range(1, 10);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: count cycles with no beat moving on either channel.
   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
         else idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("FAIL skinned_vertex_transform_core");
            $finish;
         end
      end
   end

   initial begin
      logic [3:0][5:0]  bones;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // fill every palette entry so no transform reads an unwritten word
      for (int b = 0; b < NUM_BONES; b++)
         for (int e = 0; e < 16; e++)
            send_beat(CMD_LOAD, {6'd0, 6'd0, 6'(e), 6'(b)}, '0, pick_entry(), 0, 0);

      // directed: extreme entries on bone 5, then transforms around them
      send_beat(CMD_LOAD, {6'd0, 6'd0, 6'd0, 6'd5}, '0, 32'h7FFF_FFFF, 0, 0);
      send_beat(CMD_LOAD, {6'd0, 6'd0, 6'd5, 6'd5}, '0, 32'h8000_0000, 0, 0);
      // loads with entry out of range are dropped
      send_beat(CMD_LOAD, {6'd0, 6'd0, 6'd16, 6'd5}, '0, 32'h1234_5678, 0, 0);
      send_beat(CMD_LOAD, {6'd0, 6'd0, 6'd63, 6'd63}, '0, 32'hFFFF_FFFF, 0, 0);
      bones = {6'd5, 6'd5, 6'd5, 6'd5};
      send_beat(CMD_POINT, bones, {4{16'hFFFF}},
                32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_beat(CMD_DIR, bones, {4{16'hFFFF}},
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_beat(CMD_POINT, bones, {16'd0, 16'd0, 16'd0, 16'd32768}, 0, 0, 0);
      send_beat(CMD_POINT, {6'd63, 6'd0, 6'd1, 6'd2}, '0, 32'h7FFF_FFFF, 1, 2);
      send_beat(CMD_DIR, {6'd0, 6'd63, 6'd0, 6'd63}, {4{16'd8192}},
                32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000);
      send_beat(CMD_POINT, {6'd1, 6'd2, 6'd3, 6'd4}, {4{16'd32768}},
                32'hFFFF_FFFF, 0, 32'h0000_0001);
      send_beat(CMD_SPARE, {4{6'h3F}}, {4{16'hFFFF}},
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         // hold results off for a long stretch while beats keep coming
         if (n == RANDOM_BEATS / 4) hold_now = 1;
         // let the core drain completely once
         if (n == RANDOM_BEATS / 2) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (pending != 0);
         end
         if (n == RANDOM_BEATS - 150) quiet_tail = 1;
         case ($urandom_range(0, 9))
            0, 1: send_beat(CMD_LOAD,
                            {6'($urandom()), 6'($urandom()), 6'($urandom_range(0, 63)),
                             6'($urandom_range(0, 63))},
                            {$urandom(), $urandom()}, pick_entry(), $urandom(), $urandom());
            2: send_beat(CMD_SPARE,
                         {6'($urandom()), 6'($urandom()), 6'($urandom()), 6'($urandom())},
                         {$urandom(), $urandom()}, $urandom(), $urandom(), $urandom());
            default: send_random_vertex();
         endcase
      end
      req_valid <= 1'b0;

      // drain, then give the pipeline its latency to show any extra beat
      do @(posedge clock); while (pending != 0);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("PASS skinned_vertex_transform_core");
      end else begin
         $display("FAIL skinned_vertex_transform_core");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+design
design/svt_pkg.sv
design/svt_front.sv
design/svt_back.sv
design/skinned_vertex_transform_core.sv
tb/skinned_vertex_transform_checker.sv
tb/tb.sv
